### rtl/tod_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tod_pkg;

    localparam int COORD_BITS     = 16;
    localparam int SAMPLE_BITS    = 8;
    localparam int FACTOR_BITS    = 9;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_REDUCTION_FACTOR      = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_BLOCK_WIDTH    = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_BLOCK_HEIGHT   = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] REG_OVERVIEW_BLOCK_WIDTH  = CFG_INDEX_BITS'(3);
    localparam logic [CFG_INDEX_BITS-1:0] REG_OVERVIEW_BLOCK_HEIGHT = CFG_INDEX_BITS'(4);

    localparam logic [FACTOR_BITS-1:0] RESET_REDUCTION_FACTOR     = FACTOR_BITS'(2);
    localparam logic [COORD_BITS-1:0]  RESET_SOURCE_BLOCK_SIZE    = COORD_BITS'(256);
    localparam logic [COORD_BITS-1:0]  RESET_OVERVIEW_BLOCK_SIZE  = COORD_BITS'(128);

    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [COORD_BITS-1:0]  block_origin_x;
        logic [COORD_BITS-1:0]  block_origin_y;
        logic [COORD_BITS-1:0]  pixel_col;
        logic [COORD_BITS-1:0]  pixel_row;
        logic [SAMPLE_BITS-1:0] sample_in;
    } in_word_t;

    typedef struct packed {
        logic                   keep;
        logic [COORD_BITS-1:0]  overview_tile_col;
        logic [COORD_BITS-1:0]  overview_tile_row;
        logic [COORD_BITS-1:0]  dest_col;
        logic [COORD_BITS-1:0]  dest_row;
        logic [SAMPLE_BITS-1:0] sample_out;
    } out_word_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] factor;
        logic [COORD_BITS-1:0] src_w;
        logic [COORD_BITS-1:0] src_h;
        logic [COORD_BITS-1:0] ovr_w;
        logic [COORD_BITS-1:0] ovr_h;
    } cfg_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] rem;
        logic [COORD_BITS-1:0] word;
    } div_lane_t;

    typedef struct packed {
        logic [COORD_BITS-1:0]  sx;
        logic [COORD_BITS-1:0]  sy;
        logic [COORD_BITS-1:0]  qcol;
        logic [COORD_BITS-1:0]  qrow;
        logic                   ok;
        logic [SAMPLE_BITS-1:0] sample;
    } fwd_word_t;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    function automatic div_lane_t div_step(div_lane_t lane, logic [COORD_BITS-1:0] d);
        logic [COORD_BITS:0]   trial;
        logic [COORD_BITS-1:0] diff;
        div_lane_t             res;
        trial    = {lane.rem, lane.word[COORD_BITS-1]};
        diff     = trial[COORD_BITS-1:0] - d;
        res.word = {lane.word[COORD_BITS-2:0], 1'b0};
        if (trial >= {1'b0, d})
        begin
            res.rem     = diff;
            res.word[0] = 1'b1;
        end
        else
        begin
            res.rem = trial[COORD_BITS-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/tiled_overview_decimator.sv
// Throughput: one word per cycle while out_stall stays low; the front and back halves
// are each a 16-stage restoring divider pipeline, one quotient bit per stage, joined
// by a 4-word queue.
// Reset (rst_n low, asynchronous) empties the pipelines, the queue and the output
// register and loads the configuration defaults: factor 2, source block 256 x 256,
// overview block 128 x 128.
`timescale 1ns / 1ps
`default_nettype none

module tiled_overview_decimator
    import tod_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_write,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire in_word_t                  in_word,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output out_word_t                      out_word
);

    logic [FACTOR_BITS-1:0] factor_reg;
    logic [COORD_BITS-1:0]  src_w_reg;
    logic [COORD_BITS-1:0]  src_h_reg;
    logic [COORD_BITS-1:0]  ovr_w_reg;
    logic [COORD_BITS-1:0]  ovr_h_reg;
    cfg_t                   cfg;
    logic                   push;
    fwd_word_t              push_word;
    logic                   pop;
    fwd_word_t              pop_word;
    logic                   full;
    logic                   empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg <= RESET_REDUCTION_FACTOR;
            src_w_reg  <= RESET_SOURCE_BLOCK_SIZE;
            src_h_reg  <= RESET_SOURCE_BLOCK_SIZE;
            ovr_w_reg  <= RESET_OVERVIEW_BLOCK_SIZE;
            ovr_h_reg  <= RESET_OVERVIEW_BLOCK_SIZE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_REDUCTION_FACTOR:      factor_reg <= cfg_data[FACTOR_BITS-1:0];
                REG_SOURCE_BLOCK_WIDTH:    src_w_reg  <= cfg_data[COORD_BITS-1:0];
                REG_SOURCE_BLOCK_HEIGHT:   src_h_reg  <= cfg_data[COORD_BITS-1:0];
                REG_OVERVIEW_BLOCK_WIDTH:  ovr_w_reg  <= cfg_data[COORD_BITS-1:0];
                REG_OVERVIEW_BLOCK_HEIGHT: ovr_h_reg  <= cfg_data[COORD_BITS-1:0];
                default:                   ;
            endcase
        end
    end

    // treat a zero factor or overview size as one
    always_comb
    begin
        cfg.factor = (factor_reg == '0) ? COORD_BITS'(1) : COORD_BITS'(factor_reg);
        cfg.src_w  = src_w_reg;
        cfg.src_h  = src_h_reg;
        cfg.ovr_w  = (ovr_w_reg == '0) ? COORD_BITS'(1) : ovr_w_reg;
        cfg.ovr_h  = (ovr_h_reg == '0) ? COORD_BITS'(1) : ovr_h_reg;
    end

    tod_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .full      (full),
        .push      (push),
        .push_word (push_word)
    );

    tod_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .pop_word  (pop_word),
        .full      (full),
        .empty     (empty)
    );

    tod_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .empty     (empty),
        .pop_word  (pop_word),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule

`default_nettype wire

### rtl/tod_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tod_front
    import tod_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cfg_t      cfg,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_word_t  in_word,
    input  wire logic      full,
    output logic           push,
    output fwd_word_t      push_word
);

    typedef struct packed {
        div_lane_t              ox;
        div_lane_t              oy;
        div_lane_t              col;
        div_lane_t              row;
        logic                   in_range;
        logic [SAMPLE_BITS-1:0] sample;
    } front_stage_t;

    function automatic front_stage_t front_step(front_stage_t s, logic [COORD_BITS-1:0] f);
        front_stage_t r;
        r     = s;
        r.ox  = div_step(s.ox, f);
        r.oy  = div_step(s.oy, f);
        r.col = div_step(s.col, f);
        r.row = div_step(s.row, f);
        return r;
    endfunction

    logic [COORD_BITS-1:0] valid_reg;
    front_stage_t          stage_reg  [COORD_BITS];
    front_stage_t          stage_next [COORD_BITS];
    front_stage_t          seed;
    front_stage_t          last;
    logic                  adv;
    logic                  accept;

    assign adv      = !valid_reg[COORD_BITS-1] || !full;
    assign in_stall = !adv;
    assign accept   = in_valid && adv;
    assign push     = valid_reg[COORD_BITS-1] && !full;

    always_comb
    begin
        seed.ox       = '{rem: '0, word: in_word.block_origin_x};
        seed.oy       = '{rem: '0, word: in_word.block_origin_y};
        seed.col      = '{rem: '0, word: in_word.pixel_col};
        seed.row      = '{rem: '0, word: in_word.pixel_row};
        seed.in_range = (in_word.pixel_col < cfg.src_w) && (in_word.pixel_row < cfg.src_h);
        seed.sample   = in_word.sample_in;
    end

    always_comb
    begin
        stage_next[0] = front_step(seed, cfg.factor);
        for (int k = 1; k < COORD_BITS; k++)
        begin
            stage_next[k] = front_step(stage_reg[k-1], cfg.factor);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[COORD_BITS-2:0], accept};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stage_reg <= stage_next;
        end
    end

    assign last = stage_reg[COORD_BITS-1];

    always_comb
    begin
        push_word.sx     = last.ox.word;
        push_word.sy     = last.oy.word;
        push_word.qcol   = last.col.word;
        push_word.qrow   = last.row.word;
        push_word.ok     = last.in_range && (last.col.rem == '0) && (last.row.rem == '0);
        push_word.sample = last.sample;
    end

endmodule

`default_nettype wire

### rtl/tod_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module tod_queue
    import tod_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire fwd_word_t push_word,
    input  wire logic      pop,
    output fwd_word_t      pop_word,
    output logic           full,
    output logic           empty
);

    fwd_word_t                 mem [QUEUE_DEPTH];
    fwd_word_t                 pop_word_reg;
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_next;
    logic [QUEUE_CNT_BITS-1:0] count_reg;
    logic [QUEUE_CNT_BITS-1:0] count_next;

    assign full        = (count_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign empty       = (count_reg == '0);
    assign pop_word    = pop_word_reg;
    assign rd_ptr_next = pop ? rd_ptr_reg + QUEUE_PTR_BITS'(1) : rd_ptr_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QUEUE_CNT_BITS'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QUEUE_CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_BITS'(1);
            end
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // hold the head word in a register; forward a word written into the head slot
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
        if (push && (wr_ptr_reg == rd_ptr_next))
        begin
            pop_word_reg <= push_word;
        end
        else
        begin
            pop_word_reg <= mem[rd_ptr_next];
        end
    end

endmodule

`default_nettype wire

### rtl/tod_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tod_back
    import tod_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cfg_t      cfg,
    input  wire logic      empty,
    input  wire fwd_word_t pop_word,
    output logic           pop,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_word_t      out_word
);

    typedef struct packed {
        div_lane_t              x;
        div_lane_t              y;
        logic [COORD_BITS-1:0]  qcol;
        logic [COORD_BITS-1:0]  qrow;
        logic                   ok;
        logic [SAMPLE_BITS-1:0] sample;
    } back_stage_t;

    function automatic back_stage_t back_step(back_stage_t s, logic [COORD_BITS-1:0] dw,
                                              logic [COORD_BITS-1:0] dh);
        back_stage_t r;
        r   = s;
        r.x = div_step(s.x, dw);
        r.y = div_step(s.y, dh);
        return r;
    endfunction

    logic [COORD_BITS-1:0] valid_reg;
    back_stage_t           stage_reg  [COORD_BITS];
    back_stage_t           stage_next [COORD_BITS];
    back_stage_t           seed;
    back_stage_t           last;
    logic                  out_valid_reg;
    out_word_t             out_word_reg;
    out_word_t             out_word_next;
    logic                  can_load;
    logic                  adv;
    logic [COORD_BITS:0]   dcol;
    logic [COORD_BITS:0]   drow;
    logic                  keep;

    assign can_load  = !out_valid_reg || !out_stall;
    assign adv       = !valid_reg[COORD_BITS-1] || can_load;
    assign pop       = !empty && adv;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_comb
    begin
        seed.x      = '{rem: '0, word: pop_word.sx};
        seed.y      = '{rem: '0, word: pop_word.sy};
        seed.qcol   = pop_word.qcol;
        seed.qrow   = pop_word.qrow;
        seed.ok     = pop_word.ok;
        seed.sample = pop_word.sample;
    end

    always_comb
    begin
        stage_next[0] = back_step(seed, cfg.ovr_w, cfg.ovr_h);
        for (int k = 1; k < COORD_BITS; k++)
        begin
            stage_next[k] = back_step(stage_reg[k-1], cfg.ovr_w, cfg.ovr_h);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[COORD_BITS-2:0], pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stage_reg <= stage_next;
        end
    end

    assign last = stage_reg[COORD_BITS-1];

    // zero the word (keep low) unless it is ok and falls inside the overview tile
    always_comb
    begin
        dcol = {1'b0, last.x.rem} + {1'b0, last.qcol};
        drow = {1'b0, last.y.rem} + {1'b0, last.qrow};
        keep = last.ok && (dcol < {1'b0, cfg.ovr_w}) && (drow < {1'b0, cfg.ovr_h});
        out_word_next = '0;
        if (keep)
        begin
            out_word_next.keep              = 1'b1;
            out_word_next.overview_tile_col = last.x.word;
            out_word_next.overview_tile_row = last.y.word;
            out_word_next.dest_col          = dcol[COORD_BITS-1:0];
            out_word_next.dest_row          = drow[COORD_BITS-1:0];
            out_word_next.sample_out        = last.sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            out_valid_reg <= valid_reg[COORD_BITS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load)
        begin
            out_word_reg <= out_word_next;
        end
    end

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import tod_pkg::*;

    localparam int DRAIN_CYCLES = 40;
    localparam int PHASES       = 12;
    localparam int WORDS_PER_PHASE = 140;

    typedef struct packed {
        in_word_t  stim;
        logic      known;
        out_word_t want;
    } dir_row_t;

    localparam int DIR_ROWS = 14;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{'{16'd0, 16'd0, 16'd0, 16'd0, 8'hA5}, 1'b1,
          '{1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 8'hA5}},
        '{'{16'd0, 16'd0, 16'd1, 16'd0, 8'hFF}, 1'b1, '0},
        '{'{16'd0, 16'd0, 16'd0, 16'd1, 8'h5A}, 1'b1, '0},
        '{'{16'd0, 16'd0, 16'd256, 16'd0, 8'h11}, 1'b1, '0},
        '{'{16'd0, 16'd0, 16'd0, 16'd256, 8'h22}, 1'b1, '0},
        '{'{16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 8'hFF}, 1'b1,
          '{1'b1, 16'd255, 16'd255, 16'd127, 16'd127, 8'hFF}},
        '{'{16'hFFFF, 16'hFFFF, 16'd2, 16'd0, 8'h33}, 1'b1, '0},
        '{'{16'hFFFF, 16'hFFFF, 16'd0, 16'd2, 8'h44}, 1'b1, '0},
        '{'{16'd0, 16'd0, 16'd254, 16'd254, 8'h00}, 1'b0, '0},
        '{'{16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 8'h81}, 1'b0, '0},
        '{'{16'd256, 16'd512, 16'd10, 16'd20, 8'h3C}, 1'b0, '0},
        '{'{16'h5555, 16'hAAAA, 16'h00AA, 16'h0055, 8'h55}, 1'b0, '0},
        '{'{16'hAAAA, 16'h5555, 16'h0054, 16'h00AA, 8'hAA}, 1'b0, '0},
        '{'{16'd200, 16'd100, 16'd255, 16'd255, 8'h7E}, 1'b0, '0}
    };

    // factor, source width, source height, overview width, overview height
    localparam cfg_t PRESETS [5] = '{
        '{16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
        '{16'd0, 16'd16, 16'd8, 16'd0, 16'd0},
        '{16'hFFFF, 16'd1000, 16'd1000, 16'd3, 16'd3},
        '{16'd256, 16'd0, 16'd200, 16'd1, 16'd1},
        '{16'd3, 16'd1, 16'd1, 16'hFFFF, 16'd0}
    };

    logic                      clk;
    logic                      rst_n     = 1'b0;
    logic                      cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    in_word_t                  in_word   = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    out_word_t                 out_word;

    logic [FACTOR_BITS-1:0] factor_reg;
    logic [COORD_BITS-1:0]  src_w_reg;
    logic [COORD_BITS-1:0]  src_h_reg;
    logic [COORD_BITS-1:0]  ovr_w_reg;
    logic [COORD_BITS-1:0]  ovr_h_reg;

    out_word_t pending_words [$];
    out_word_t want;
    int        mismatches = 0;
    int        gap_pct    = 0;
    int        stall_pct  = 0;

    tiled_overview_decimator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #6_000_000;
        $display("tiled_overview_decimator: mismatch");
        $finish;
    end

    function automatic int unsigned nz(int unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic out_word_t decimate(in_word_t w);
        int unsigned f;
        int unsigned ow;
        int unsigned oh;
        int unsigned ox;
        int unsigned oy;
        int unsigned col;
        int unsigned row;
        int unsigned sx;
        int unsigned sy;
        int unsigned dc;
        int unsigned dr;
        out_word_t   r;
        f   = nz(32'(factor_reg));
        ow  = nz(32'(ovr_w_reg));
        oh  = nz(32'(ovr_h_reg));
        ox  = 32'(w.block_origin_x);
        oy  = 32'(w.block_origin_y);
        col = 32'(w.pixel_col);
        row = 32'(w.pixel_row);
        sx  = ox / f;
        sy  = oy / f;
        dc  = sx % ow + col / f;
        dr  = sy % oh + row / f;
        r   = '0;
        if (col % f == 0 && row % f == 0 &&
            col < 32'(src_w_reg) && row < 32'(src_h_reg) && dc < ow && dr < oh)
        begin
            r.keep              = 1'b1;
            r.overview_tile_col = COORD_BITS'(sx / ow);
            r.overview_tile_row = COORD_BITS'(sy / oh);
            r.dest_col          = COORD_BITS'(dc);
            r.dest_row          = COORD_BITS'(dr);
            r.sample_out        = w.sample_in;
        end
        return r;
    endfunction

    // mostly factor-multiple positions, sometimes with aligned origins, so that samples survive
    function automatic in_word_t random_word();
        int unsigned f;
        int unsigned ow;
        int unsigned oh;
        in_word_t    w;
        f  = nz(32'(factor_reg));
        ow = nz(32'(ovr_w_reg));
        oh = nz(32'(ovr_h_reg));
        w.block_origin_x = COORD_BITS'($urandom);
        w.block_origin_y = COORD_BITS'($urandom);
        w.pixel_col      = COORD_BITS'($urandom);
        w.pixel_row      = COORD_BITS'($urandom);
        w.sample_in      = SAMPLE_BITS'($urandom);
        if ($urandom_range(0, 9) < 7)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                w.block_origin_x = COORD_BITS'(f * ow * $urandom_range(0, 65535 / (f * ow)));
                w.block_origin_y = COORD_BITS'(f * oh * $urandom_range(0, 65535 / (f * oh)));
            end
            w.pixel_col = COORD_BITS'(f * $urandom_range(0, ow));
            w.pixel_row = COORD_BITS'(f * $urandom_range(0, oh));
        end
        return w;
    endfunction

    task automatic write_cfg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] d);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        case (idx)
            REG_REDUCTION_FACTOR:      factor_reg = d[FACTOR_BITS-1:0];
            REG_SOURCE_BLOCK_WIDTH:    src_w_reg  = d;
            REG_SOURCE_BLOCK_HEIGHT:   src_h_reg  = d;
            REG_OVERVIEW_BLOCK_WIDTH:  ovr_w_reg  = d;
            REG_OVERVIEW_BLOCK_HEIGHT: ovr_h_reg  = d;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic apply_cfg(input cfg_t c);
        write_cfg(REG_REDUCTION_FACTOR, c.factor);
        write_cfg(REG_SOURCE_BLOCK_WIDTH, c.src_w);
        write_cfg(REG_SOURCE_BLOCK_HEIGHT, c.src_h);
        write_cfg(REG_OVERVIEW_BLOCK_WIDTH, c.ovr_w);
        write_cfg(REG_OVERVIEW_BLOCK_HEIGHT, c.ovr_h);
        for (int i = int'(REG_OVERVIEW_BLOCK_HEIGHT) + 1; i < 2 ** CFG_INDEX_BITS; i++)
            write_cfg(CFG_INDEX_BITS'(i), CFG_DATA_BITS'($urandom));
        cfg_write <= 1'b0;
    endtask

    task automatic send_word(input in_word_t w, input out_word_t result);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_words.push_back(result);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_words.size() == 0)
            begin
                mismatches++;
                $display("%0t: no word expected, got %p", $time, out_word);
            end
            else
            begin
                want = pending_words.pop_front();
                if (out_word !== want)
                begin
                    mismatches++;
                    $display("%0t: expected keep=%0d tile=(%0d,%0d) dest=(%0d,%0d) sample=%0h",
                             $time, want.keep, want.overview_tile_col,
                             want.overview_tile_row, want.dest_col, want.dest_row,
                             want.sample_out);
                    $display("%0t:   actual keep=%0d tile=(%0d,%0d) dest=(%0d,%0d) sample=%0h",
                             $time, out_word.keep, out_word.overview_tile_col,
                             out_word.overview_tile_row, out_word.dest_col, out_word.dest_row,
                             out_word.sample_out);
                end
            end
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    initial
    begin
        cfg_t     c;
        in_word_t w;
        factor_reg = RESET_REDUCTION_FACTOR;
        src_w_reg  = RESET_SOURCE_BLOCK_SIZE;
        src_h_reg  = RESET_SOURCE_BLOCK_SIZE;
        ovr_w_reg  = RESET_OVERVIEW_BLOCK_SIZE;
        ovr_h_reg  = RESET_OVERVIEW_BLOCK_SIZE;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < DIR_ROWS; i++)
            send_word(DIRECTED[i].stim,
                      DIRECTED[i].known ? DIRECTED[i].want : decimate(DIRECTED[i].stim));
        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                drain();
                if (p <= 5)
                    c = PRESETS[p - 1];
                else
                begin
                    c.factor = ($urandom_range(0, 3) == 0) ? COORD_BITS'($urandom)
                                                           : COORD_BITS'($urandom_range(1, 8));
                    c.src_w  = ($urandom_range(0, 3) == 0) ? COORD_BITS'($urandom)
                                                           : COORD_BITS'($urandom_range(1, 300));
                    c.src_h  = ($urandom_range(0, 3) == 0) ? COORD_BITS'($urandom)
                                                           : COORD_BITS'($urandom_range(1, 300));
                    c.ovr_w  = ($urandom_range(0, 3) == 0) ? COORD_BITS'($urandom)
                                                           : COORD_BITS'($urandom_range(1, 200));
                    c.ovr_h  = ($urandom_range(0, 3) == 0) ? COORD_BITS'($urandom)
                                                           : COORD_BITS'($urandom_range(1, 200));
                end
                apply_cfg(c);
            end
            case (p % 4)
                0:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct   = 81;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct   = 0;
                    stall_pct = 81;
                end
                default:
                begin
                    gap_pct   = 37;
                    stall_pct = 37;
                end
            endcase
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                w = random_word();
                send_word(w, decimate(w));
            end
        end
        drain();
        if (mismatches == 0)
            $display("tiled_overview_decimator: match");
        else
            $display("tiled_overview_decimator: mismatch");
        $finish;
    end

endmodule

### tiled_overview_decimator.f
rtl/tod_pkg.sv
rtl/tod_front.sv
rtl/tod_queue.sv
rtl/tod_back.sv
rtl/tiled_overview_decimator.sv
tb/sv/tb.sv
